FILE: design/top_k_score_selector_assert.svh
// Assertion macros used by the top-k score selector back end.
`ifndef TOP_K_SCORE_SELECTOR_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TKS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("top_k_score_selector: check failed");

// Next-cycle implication, disabled while reset is low.
`define TKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("top_k_score_selector: check failed");

`endif

FILE: design/tks_pkg.sv
// Types and constants shared by the top-k score selector.
`timescale 1ns / 1ps

package tks_pkg;

    localparam int MAX_RANKS_DEF   = 8;
    localparam int MAX_CLASSES_DEF = 4096;
    localparam int RESULT_LIMIT    = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam int SCORE_W = 16;
    localparam int INDEX_W = 12;
    localparam int RANK_W  = 3;
    localparam int COUNT_W = 4;

    localparam logic [COUNT_W-1:0] DEFAULT_RESULTS = 4'd5;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               last_score;
    } t_in_word;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [INDEX_W-1:0] class_index;
        logic [SCORE_W-1:0] ranked_score;
        logic               slot_valid;
        logic               overflowed;
        logic               last_result;
    } t_out_word;

    // Classified score handed from the front to the back.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [INDEX_W-1:0] index;
        logic               in_range;
        logic               last;
        logic               ovf;
    } t_cls_word;

endpackage

FILE: design/tks_front.sv
// Front end: accept scores, number them and flag capacity overflow.
`timescale 1ns / 1ps

module tks_front #(
    parameter int MAX_CLASSES = tks_pkg::MAX_CLASSES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tks_pkg::t_in_word   i_item,
    input  logic                i_full,
    output logic                o_wr,
    output tks_pkg::t_cls_word  o_word
);

    localparam int CW    = $clog2(MAX_CLASSES + 1);
    localparam int EXT_W = CW + tks_pkg::INDEX_W;

    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             in_range;
    logic [EXT_W-1:0] cnt_ext;

    assign in_range = r_cnt < CW'(MAX_CLASSES);
    assign cnt_ext  = EXT_W'(r_cnt);
    assign o_wr     = i_push && !i_full;

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (o_wr) begin
            if (i_item.last_score) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else if (in_range) begin
                n_cnt = r_cnt + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    always_comb begin
        o_word.score    = i_item.score;
        o_word.index    = cnt_ext[tks_pkg::INDEX_W-1:0];
        o_word.in_range = in_range;
        o_word.last     = i_item.last_score;
        o_word.ovf      = r_ovf || !in_range;
    end

endmodule

FILE: design/tks_queue.sv
// Short queue of classified scores between front and back.
`timescale 1ns / 1ps

module tks_queue #(
    parameter int DEPTH = tks_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  tks_pkg::t_cls_word  i_word,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_rd,
    output tks_pkg::t_cls_word  o_word
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    tks_pkg::t_cls_word r_mem [DEPTH];
    logic [PW-1:0]      r_wp, r_rp, n_wp, n_rp;
    logic [NW-1:0]      r_cnt, n_cnt;
    logic               do_wr, do_rd;

    assign o_full  = r_cnt == NW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_word  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule

FILE: design/tks_back.sv
// Back end: sorted insertion of kept scores and ranked result emission.
`timescale 1ns / 1ps
`include "top_k_score_selector_assert.svh"

module tks_back #(
    parameter int MAX_RANKS = tks_pkg::MAX_RANKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  tks_pkg::t_cls_word             i_word,
    output logic                           o_rd,
    input  logic [tks_pkg::COUNT_W-1:0]    i_result_count,
    input  logic                           i_pop,
    output logic                           o_empty,
    output tks_pkg::t_out_word             o_result
);

    localparam int RL = (MAX_RANKS < tks_pkg::RESULT_LIMIT) ? MAX_RANKS
                                                           : tks_pkg::RESULT_LIMIT;
    localparam int COUNT_W = tks_pkg::COUNT_W;
    localparam int SCORE_W = tks_pkg::SCORE_W;
    localparam int INDEX_W = tks_pkg::INDEX_W;
    localparam int RANK_W  = tks_pkg::RANK_W;

    // kept list, sorted high to low, valid entries packed at the front
    logic [SCORE_W-1:0] r_score [MAX_RANKS];
    logic [INDEX_W-1:0] r_idx   [MAX_RANKS];
    logic [MAX_RANKS-1:0] r_kv;

    logic [SCORE_W-1:0] nl_score [MAX_RANKS];
    logic [INDEX_W-1:0] nl_idx   [MAX_RANKS];
    logic [MAX_RANKS-1:0] nl_kv;
    logic [MAX_RANKS-1:0] ge;

    logic [SCORE_W-1:0] ld_score [MAX_RANKS];
    logic [INDEX_W-1:0] ld_idx   [MAX_RANKS];
    logic [MAX_RANKS-1:0] ld_kv;

    // emission shift line
    logic [SCORE_W-1:0] r_e_score [RL];
    logic [INDEX_W-1:0] r_e_idx   [RL];
    logic [RL-1:0]      r_e_kv;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [RANK_W-1:0]  r_rank, n_rank;
    logic               r_ovf, n_ovf;

    logic               ins, load, shift, emit_free;
    logic [COUNT_W-1:0] n_req;

    assign o_empty   = r_left == '0;
    assign shift     = i_pop && !o_empty;
    assign emit_free = o_empty || (shift && r_left == COUNT_W'(1));
    assign o_rd      = !i_q_empty && (!i_word.last || emit_free);
    assign ins       = o_rd && i_word.in_range;
    assign load      = o_rd && i_word.last;

    always_comb begin
        if (i_result_count == '0) begin
            n_req = COUNT_W'(1);
        end else if (i_result_count > COUNT_W'(RL)) begin
            n_req = COUNT_W'(RL);
        end else begin
            n_req = i_result_count;
        end
    end

    for (genvar i = 0; i < MAX_RANKS; i++) begin : g_slot
        assign ge[i] = !r_kv[i] || (i_word.score > r_score[i]);
        if (i == 0) begin : g_head
            assign nl_score[i] = ge[i] ? i_word.score : r_score[i];
            assign nl_idx[i]   = ge[i] ? i_word.index : r_idx[i];
            assign nl_kv[i]    = ge[i] ? 1'b1 : r_kv[i];
        end else begin : g_tail
            assign nl_score[i] = !ge[i] ? r_score[i] :
                                 (ge[i-1] ? r_score[i-1] : i_word.score);
            assign nl_idx[i]   = !ge[i] ? r_idx[i] :
                                 (ge[i-1] ? r_idx[i-1] : i_word.index);
            assign nl_kv[i]    = !ge[i] ? r_kv[i] :
                                 (ge[i-1] ? r_kv[i-1] : 1'b1);
        end
        assign ld_score[i] = ins ? nl_score[i] : r_score[i];
        assign ld_idx[i]   = ins ? nl_idx[i]   : r_idx[i];
        assign ld_kv[i]    = ins ? nl_kv[i]    : r_kv[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv <= '0;
        end else if (load) begin
            r_kv <= '0;
        end else if (ins) begin
            r_kv <= nl_kv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins) begin
            r_score <= nl_score;
            r_idx   <= nl_idx;
        end
    end

    always_comb begin
        n_left = r_left;
        n_rank = r_rank;
        n_ovf  = r_ovf;
        if (load) begin
            n_left = n_req;
            n_rank = '0;
            n_ovf  = i_word.ovf;
        end else if (shift) begin
            n_left = r_left - 1'b1;
            n_rank = r_rank + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_rank <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_left <= n_left;
            r_rank <= n_rank;
            r_ovf  <= n_ovf;
        end
    end

    for (genvar i = 0; i < RL; i++) begin : g_emit
        always_ff @(posedge i_clk) begin
            if (load) begin
                r_e_score[i] <= ld_score[i];
                r_e_idx[i]   <= ld_idx[i];
                r_e_kv[i]    <= ld_kv[i];
            end else if (shift) begin
                if (i < RL - 1) begin
                    r_e_score[i] <= r_e_score[(i + 1) % RL];
                    r_e_idx[i]   <= r_e_idx[(i + 1) % RL];
                    r_e_kv[i]    <= r_e_kv[(i + 1) % RL];
                end else begin
                    r_e_kv[i]    <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_result.rank         = r_rank;
        o_result.class_index  = r_e_kv[0] ? r_e_idx[0] : '0;
        o_result.ranked_score = r_e_kv[0] ? r_e_score[0] : '0;
        o_result.slot_valid   = r_e_kv[0];
        o_result.overflowed   = r_ovf;
        o_result.last_result  = r_left == COUNT_W'(1);
    end

    `TKS_ASSERT_IMPL(a_left_bound, i_clk, i_rst_n, 1'b1, r_left <= COUNT_W'(RL))
    `TKS_ASSERT_IMPL(a_kept_packed, i_clk, i_rst_n, 1'b1, ((r_kv >> 1) & ~r_kv) == '0)
    `TKS_ASSERT_NEXT(a_last_loads, i_clk, i_rst_n, load, (r_left != '0) && (r_rank == '0))
    `TKS_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, load && !o_empty, emit_free)

endmodule

FILE: design/top_k_score_selector.sv
// Top level of the streaming top-k score selector.
`timescale 1ns / 1ps
// Usage:
//   Input channel (push/full): one word per score, score as unsigned Q0.16 and
//   last_score marking the end of a vector. A word is taken on a rising edge with
//   push high and full low. Class indices are the position of the score in the vector.
//   Result channel (empty/pop): while empty is low, o_result holds the oldest ranked
//   word; pop high on an edge with empty low takes it. A vector yields result_count
//   words (0 reads as 1, clamped to MAX_RANKS and 8), rank 0 first, last_result on the
//   final one.
//   Config: i_cfg_we writes i_cfg_wdata into result_count; write only while idle.
// Timing:
//   One score per cycle unless a last score waits on pending results. The insert compares the new score against every
//   kept slot in parallel. The first result shows once the last score has passed the queue
//   and been loaded into the emission line; then one result per cycle as long as pop stays high.
//   Emission overlaps the next vector's scores; a last score waits in the two-word
//   queue only while the previous vector still has results pending, and full rises
//   when that queue fills.
// Reset: synchronous, active low; clears the kept list, counters and pending results,
//   and sets result_count to 5.
// Stall: with pop low, results hold steady and the input side keeps accepting until
//   the queue fills behind a last score that has to wait.

module top_k_score_selector #(
    parameter int MAX_RANKS   = tks_pkg::MAX_RANKS_DEF,
    parameter int MAX_CLASSES = tks_pkg::MAX_CLASSES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  tks_pkg::t_in_word            i_item,
    output logic                         empty,
    input  logic                         pop,
    output tks_pkg::t_out_word           o_result,
    input  logic                         i_cfg_we,
    input  logic [tks_pkg::COUNT_W-1:0]  i_cfg_wdata
);

    logic [tks_pkg::COUNT_W-1:0] r_result_count;

    // classified score path between the front and the back
    logic               f_wr;
    tks_pkg::t_cls_word f_word;
    logic               q_empty;
    logic               q_rd;
    tks_pkg::t_cls_word q_word;

    // hold the result count; reset to the default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_count <= tks_pkg::DEFAULT_RESULTS;
        end else if (i_cfg_we) begin
            r_result_count <= i_cfg_wdata;
        end
    end

    // number scores, flag those beyond capacity
    tks_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_full  (full),
        .o_wr    (f_wr),
        .o_word  (f_word)
    );

    // decouple acceptance from insertion and emission
    tks_queue #(
        .DEPTH(tks_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_word  (f_word),
        .o_full  (full),
        .o_empty (q_empty),
        .i_rd    (q_rd),
        .o_word  (q_word)
    );

    // insert into the sorted list, snapshot and drain on a last score
    tks_back #(
        .MAX_RANKS(MAX_RANKS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_word         (q_word),
        .o_rd           (q_rd),
        .i_result_count (r_result_count),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result       (o_result)
    );

endmodule

FILE: tb/top_k_score_selector_test.sv
// Self-checking testbench for the streaming top-k score selector.
`timescale 1ns / 1ps

module top_k_score_selector_test;

    localparam int COUNT_W         = tks_pkg::COUNT_W;
    localparam int SCORE_W         = tks_pkg::SCORE_W;
    localparam int INDEX_W         = tks_pkg::INDEX_W;
    localparam int RANK_W          = tks_pkg::RANK_W;
    localparam int MAX_RANKS_DEF   = tks_pkg::MAX_RANKS_DEF;
    localparam int MAX_CLASSES_DEF = tks_pkg::MAX_CLASSES_DEF;
    localparam int RESULT_LIMIT    = tks_pkg::RESULT_LIMIT;

    // Kinds of rows in the directed stimulus table.
    typedef enum logic [0:0] {
        ROW_CFG  = 1'b0,
        ROW_ITEM = 1'b1
    } t_row_kind;

    // One directed row: either a result_count write or one score word. A row with
    // fixed_exp set carries the single result word it must produce, typed in by hand.
    typedef struct {
        t_row_kind          kind;
        logic [COUNT_W-1:0] count;
        logic [SCORE_W-1:0] score;
        logic               last;
        logic               fixed_exp;
        tks_pkg::t_out_word exp_word;
    } t_dir_row;

    // Score word waiting to be pushed, with its optional hand-typed result.
    typedef struct {
        tks_pkg::t_in_word  word;
        logic               fixed_exp;
        tks_pkg::t_out_word exp_word;
    } t_feed_word;

    localparam tks_pkg::t_out_word NO_WORD  = '0;
    localparam int                 DIR_ROWS = 27;

    // Directed part: default count after reset, ties, empty ranks, extreme scores,
    // count zero, counts above the rank capacity.
    t_dir_row dir_table [0:DIR_ROWS-1] = '{
        // count 5 after reset: equal scores keep the earlier index, rank 4 stays empty
        '{ROW_ITEM, 4'd0,  16'h1234, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h8000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h8000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0001, 1'b1, 1'b0, NO_WORD},
        // count 1: vectors at both ends of the score range, the last a tie of two zeros
        '{ROW_CFG,  4'd1,  16'h0000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'hFFFF, 1'b1, 1'b1, '{3'd0, 12'd0, 16'hFFFF, 1'b1, 1'b0, 1'b1}},
        '{ROW_ITEM, 4'd0,  16'h0000, 1'b1, 1'b1, '{3'd0, 12'd0, 16'h0000, 1'b1, 1'b0, 1'b1}},
        '{ROW_ITEM, 4'd0,  16'h0000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0000, 1'b1, 1'b1, '{3'd0, 12'd0, 16'h0000, 1'b1, 1'b0, 1'b1}},
        // count 0 reads as 1
        '{ROW_CFG,  4'd0,  16'h0000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h7FFF, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'hFFFF, 1'b1, 1'b1, '{3'd0, 12'd1, 16'hFFFF, 1'b1, 1'b0, 1'b1}},
        // count 15 clamps to 8; nine rising scores push the first one out
        '{ROW_CFG,  4'd15, 16'h0000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0001, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0002, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0003, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0004, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0005, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0006, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0007, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0008, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h0009, 1'b1, 1'b0, NO_WORD},
        // count 8 with one score: seven empty ranks
        '{ROW_CFG,  4'd8,  16'h0000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'hABCD, 1'b1, 1'b0, NO_WORD},
        // count 9 also clamps to 8
        '{ROW_CFG,  4'd9,  16'h0000, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'h5555, 1'b0, 1'b0, NO_WORD},
        '{ROW_ITEM, 4'd0,  16'hAAAA, 1'b1, 1'b0, NO_WORD}
    };

    // DUT ports; every input starts at a known value.
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic               full;
    tks_pkg::t_in_word  i_item      = '0;
    logic               empty;
    logic               pop         = 1'b0;
    tks_pkg::t_out_word o_result;
    logic               i_cfg_we    = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;

    // Words still to push, and ranked words the block still owes us.
    t_feed_word         score_feed [$];
    tks_pkg::t_out_word ranking_due [$];

    // Idle rates in percent for the push side and the pop side.
    int unsigned feed_idle_pct  = 0;
    int unsigned drain_stall_pct = 0;
    int unsigned error_total    = 0;

    // Predictor state: the kept list, the vector position and the register copy.
    logic [SCORE_W-1:0] kept_score [MAX_RANKS_DEF];
    logic [INDEX_W-1:0] kept_class [MAX_RANKS_DEF];
    logic               kept_ok    [MAX_RANKS_DEF];
    logic [12:0]        seen_count         = '0;
    logic               capacity_hit       = 1'b0;
    logic [COUNT_W-1:0] results_per_vector = tks_pkg::DEFAULT_RESULTS;

    top_k_score_selector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or never drains.
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < MAX_RANKS_DEF; i++) begin
            kept_score[i] = '0;
            kept_class[i] = '0;
            kept_ok[i]    = 1'b0;
        end
    end

    // Advance the predicted ranking by one accepted score word and return the
    // ranked words it releases (none unless the word closes a vector).
    task automatic predict_ranking(input tks_pkg::t_in_word w,
                                   output tks_pkg::t_out_word words [$]);
        int                 pos;
        int                 n;
        tks_pkg::t_out_word r;
        words = {};
        if (seen_count < MAX_CLASSES_DEF) begin
            // Insert ahead of the first empty slot or strictly smaller score.
            pos = MAX_RANKS_DEF;
            for (int i = 0; i < MAX_RANKS_DEF; i++) begin
                if (pos == MAX_RANKS_DEF && (!kept_ok[i] || w.score > kept_score[i]))
                    pos = i;
            end
            if (pos < MAX_RANKS_DEF) begin
                for (int i = MAX_RANKS_DEF - 1; i > pos; i--) begin
                    kept_score[i] = kept_score[i-1];
                    kept_class[i] = kept_class[i-1];
                    kept_ok[i]    = kept_ok[i-1];
                end
                kept_score[pos] = w.score;
                kept_class[pos] = seen_count[INDEX_W-1:0];
                kept_ok[pos]    = 1'b1;
            end
            seen_count++;
        end else begin
            // Past capacity: drop the score, remember the overflow.
            capacity_hit = 1'b1;
        end
        if (w.last_score) begin
            n = results_per_vector;
            if (n == 0)
                n = 1;
            if (n > MAX_RANKS_DEF)
                n = MAX_RANKS_DEF;
            if (n > RESULT_LIMIT)
                n = RESULT_LIMIT;
            for (int k = 0; k < n; k++) begin
                r.rank         = k[RANK_W-1:0];
                r.class_index  = kept_ok[k] ? kept_class[k] : '0;
                r.ranked_score = kept_ok[k] ? kept_score[k] : '0;
                r.slot_valid   = kept_ok[k];
                r.overflowed   = capacity_hit;
                r.last_result  = (k == n - 1);
                words = {words, r};
            end
            // Start the next vector from a clean list.
            for (int i = 0; i < MAX_RANKS_DEF; i++) begin
                kept_score[i] = '0;
                kept_class[i] = '0;
                kept_ok[i]    = 1'b0;
            end
            seen_count   = '0;
            capacity_hit = 1'b0;
        end
    endtask

    // Compare one popped word field by field against the oldest owed word.
    task automatic check_ranked_word(input tks_pkg::t_out_word want,
                                     input tks_pkg::t_out_word got);
        if (got.rank !== want.rank) begin
            $error("rank: expected %0d, got %0d", want.rank, got.rank);
            error_total++;
        end
        if (got.class_index !== want.class_index) begin
            $error("class_index: expected %0d, got %0d", want.class_index, got.class_index);
            error_total++;
        end
        if (got.ranked_score !== want.ranked_score) begin
            $error("ranked_score: expected 0x%04h, got 0x%04h",
                   want.ranked_score, got.ranked_score);
            error_total++;
        end
        if (got.slot_valid !== want.slot_valid) begin
            $error("slot_valid: expected %0d, got %0d", want.slot_valid, got.slot_valid);
            error_total++;
        end
        if (got.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
            error_total++;
        end
        if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
            error_total++;
        end
    endtask

    // Queue one score word for the push side.
    task automatic queue_score(input logic [SCORE_W-1:0] score, input logic last);
        t_feed_word f;
        f.word.score      = score;
        f.word.last_score = last;
        f.fixed_exp       = 1'b0;
        f.exp_word        = NO_WORD;
        score_feed = {score_feed, f};
    endtask

    // Mostly full-range scores; a share from a small pool so that ties are common.
    function automatic logic [SCORE_W-1:0] pick_score();
        logic [SCORE_W-1:0] s;
        s = SCORE_W'($urandom);
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
                0:       s = 16'h0000;
                1:       s = 16'hFFFF;
                2:       s = 16'h8000;
                3:       s = 16'h0001;
                default: s = 16'h4000;
            endcase
        end
        return s;
    endfunction

    // Write result_count once the block is idle: nothing left to push, nothing owed,
    // then a wait for the output pipeline to settle.
    task automatic write_result_count(input logic [COUNT_W-1:0] value);
        while (score_feed.size() != 0 || push || ranking_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        results_per_vector = value;
    endtask

    // Push side: take an accepted word into the predictor, then hold, raise or drop
    // push for the next edge. Push stays up on a waiting word until it is taken.
    initial begin : feed_side
        t_feed_word         head;
        tks_pkg::t_out_word produced [$];
        logic               took;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n)
                continue;
            took = push && !full;
            if (took) begin
                head = score_feed.pop_front();
                predict_ranking(head.word, produced);
                if (head.fixed_exp)
                    ranking_due = {ranking_due, head.exp_word};
                else
                    foreach (produced[i])
                        ranking_due = {ranking_due, produced[i]};
            end
            if (!push || took) begin
                if (score_feed.size() != 0 && $urandom_range(99) >= feed_idle_pct) begin
                    push   <= 1'b1;
                    i_item <= score_feed[0].word;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Pop side: check every word taken at this edge, then pick pop for the next one.
    initial begin : drain_side
        tks_pkg::t_out_word want;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n)
                continue;
            if (pop && !empty) begin
                if (ranking_due.size() == 0) begin
                    $error("unexpected result word: rank %0d class_index %0d",
                           o_result.rank, o_result.class_index);
                    error_total++;
                end else begin
                    want = ranking_due.pop_front();
                    check_ranked_word(want, o_result);
                end
            end
            pop <= ($urandom_range(99) >= drain_stall_pct);
        end
    end

    // Sequencer: reset, directed table, random phases, drain, verdict.
    initial begin : sequencer
        t_feed_word          f;
        int                  budget;
        int                  len;
        logic [COUNT_W-1:0]  phase_count [8];
        phase_count = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd7, 4'd2, 4'd5};

        // Hold reset low, then release it.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under light idling on both sides.
        feed_idle_pct   = 10;
        drain_stall_pct = 10;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_CFG) begin
                write_result_count(dir_table[r].count);
            end else begin
                f.word.score      = dir_table[r].score;
                f.word.last_score = dir_table[r].last;
                f.fixed_exp       = dir_table[r].fixed_exp;
                f.exp_word        = dir_table[r].exp_word;
                score_feed = {score_feed, f};
            end
        end

        // Random phases, cycling through the idling patterns and register values.
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin feed_idle_pct = 0;  drain_stall_pct = 0;  end
                1: begin feed_idle_pct = 86; drain_stall_pct = 0;  end
                2: begin feed_idle_pct = 0;  drain_stall_pct = 86; end
                default: begin feed_idle_pct = 10; drain_stall_pct = 10; end
            endcase
            write_result_count(p == 7 ? COUNT_W'($urandom_range(15)) : phase_count[p]);
            budget = 12;
            while (budget > 0) begin
                // Mostly short vectors, now and then one longer than the rank list.
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(8, 1);
                for (int j = 0; j < len; j++)
                    queue_score(pick_score(), j == len - 1);
                budget -= len;
            end
        end

        // Drain: keep pop up so stray words show, then allow the pipeline to settle.
        drain_stall_pct = 0;
        while (score_feed.size() != 0 || push || ranking_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (error_total == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/tks_pkg.sv
design/tks_front.sv
design/tks_queue.sv
design/tks_back.sv
design/top_k_score_selector.sv
tb/top_k_score_selector_test.sv
